// ----- rtl/core/pireg_pkg.sv -----
// Shared types and constants for the clamped PI regulator.
// No dependencies; every other file in rtl/core refers to this package.
package pireg_pkg;

    // Gain registers are signed fixed point of a fixed width.
    localparam int unsigned GAIN_W = 16;

    // Proportional gain after reset: 1.0 in Q8.8.
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET = 16'sd256;

    // Width of the configuration register index.
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT    = 3'd0,
        CFG_PROP_GAIN   = 3'd1,
        CFG_INTEG_GAIN  = 3'd2,
        CFG_OUT_MIN     = 3'd3,
        CFG_OUT_MAX     = 3'd4,
        CFG_LOOP_ENABLE = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_CLEAR  = 1'b1
    } t_func;

endpackage

// ----- rtl/core/pireg_cfg.sv -----
// Configuration register file of the clamped PI regulator.
// Depends on pireg_pkg for register indexes and reset values.
module pireg_cfg #(
    parameter int unsigned DATA_WIDTH = 16,
    parameter int unsigned CFG_W      = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [pireg_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [CFG_W-1:0]                     i_cfg_wr_data,
    output logic signed [DATA_WIDTH-1:0]         o_setpoint,
    output logic signed [pireg_pkg::GAIN_W-1:0]  o_prop_gain,
    output logic signed [pireg_pkg::GAIN_W-1:0]  o_integ_gain,
    output logic signed [DATA_WIDTH-1:0]         o_out_min,
    output logic [DATA_WIDTH-2:0]                o_out_max,
    output logic                                 o_loop_enable
);

    logic signed [DATA_WIDTH-1:0]        r_setpoint;
    logic signed [pireg_pkg::GAIN_W-1:0] r_prop_gain;
    logic signed [pireg_pkg::GAIN_W-1:0] r_integ_gain;
    logic signed [DATA_WIDTH-1:0]        r_out_min;
    logic [DATA_WIDTH-2:0]               r_out_max;
    logic                                r_loop_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= '0;
            r_prop_gain   <= pireg_pkg::PROP_GAIN_RESET;
            r_integ_gain  <= '0;
            r_out_min     <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            r_out_max     <= '1;
            r_loop_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                pireg_pkg::CFG_SETPOINT: begin
                    r_setpoint <= $signed(i_cfg_wr_data[DATA_WIDTH-1:0]);
                end
                pireg_pkg::CFG_PROP_GAIN: begin
                    r_prop_gain <= $signed(i_cfg_wr_data[pireg_pkg::GAIN_W-1:0]);
                end
                pireg_pkg::CFG_INTEG_GAIN: begin
                    r_integ_gain <= $signed(i_cfg_wr_data[pireg_pkg::GAIN_W-1:0]);
                end
                pireg_pkg::CFG_OUT_MIN: begin
                    r_out_min <= $signed(i_cfg_wr_data[DATA_WIDTH-1:0]);
                end
                pireg_pkg::CFG_OUT_MAX: begin
                    r_out_max <= i_cfg_wr_data[DATA_WIDTH-2:0];
                end
                pireg_pkg::CFG_LOOP_ENABLE: begin
                    r_loop_enable <= i_cfg_wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_setpoint    = r_setpoint;
    assign o_prop_gain   = r_prop_gain;
    assign o_integ_gain  = r_integ_gain;
    assign o_out_min     = r_out_min;
    assign o_out_max     = r_out_max;
    assign o_loop_enable = r_loop_enable;

endmodule

// ----- rtl/core/pireg_integ.sv -----
// Error and integrator stage of the clamped PI regulator: forms the error,
// updates the clamped integral and registers error and unclamped sum.
// Depends on pireg_pkg for the function codes.
module pireg_integ #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic                          i_func,
    input  logic signed [DATA_WIDTH-1:0]  i_meas,
    input  logic signed [DATA_WIDTH-1:0]  i_setpoint,
    input  logic [DATA_WIDTH-2:0]         i_out_max,
    input  logic                          i_loop_enable,
    output logic                          o_valid,
    output logic signed [DATA_WIDTH:0]    o_err,
    output logic signed [DATA_WIDTH+1:0]  o_sum
);

    localparam int unsigned ERR_W = DATA_WIDTH + 1;
    localparam int unsigned SUM_W = DATA_WIDTH + 2;

    logic signed [DATA_WIDTH-1:0] r_integral;
    logic signed [DATA_WIDTH-1:0] n_integral;
    logic                         r_valid;
    logic signed [ERR_W-1:0]      r_err;
    logic signed [SUM_W-1:0]      r_sum;

    logic signed [ERR_W-1:0] w_err;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_lim_hi;
    logic signed [SUM_W-1:0] w_lim_lo;
    logic signed [SUM_W-1:0] w_sum_clamped;
    logic                    w_is_sample;
    logic                    w_is_clear;

    assign w_is_sample = i_valid && (i_func == pireg_pkg::FUNC_SAMPLE) && i_loop_enable;
    assign w_is_clear  = i_valid && (i_func == pireg_pkg::FUNC_CLEAR);

    always_comb begin
        w_err    = ERR_W'(i_meas) - ERR_W'(i_setpoint);
        w_sum    = SUM_W'(r_integral) + SUM_W'(w_err);
        w_lim_hi = $signed({3'b000, i_out_max});
        w_lim_lo = -w_lim_hi;
        if (w_sum > w_lim_hi) begin
            w_sum_clamped = w_lim_hi;
        end else if (w_sum < w_lim_lo) begin
            w_sum_clamped = w_lim_lo;
        end else begin
            w_sum_clamped = w_sum;
        end
    end

    always_comb begin
        n_integral = r_integral;
        if (w_is_clear) begin
            n_integral = '0;
        end else if (w_is_sample) begin
            // The clamped sum always fits the stored width.
            n_integral = w_sum_clamped[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_valid    <= 1'b0;
        end else if (i_adv) begin
            r_integral <= n_integral;
            r_valid    <= w_is_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_err <= w_err;
            r_sum <= w_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_sum   = r_sum;

endmodule

// ----- rtl/core/pireg_drive.sv -----
// Drive stage of the clamped PI regulator: the two gain products, then the
// shifted sum clamped to the output limits, each behind its own register.
// Depends on pireg_pkg for the gain width.
module pireg_drive #(
    parameter int unsigned DATA_WIDTH     = 16,
    parameter int unsigned GAIN_FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic signed [DATA_WIDTH:0]           i_err,
    input  logic signed [DATA_WIDTH+1:0]         i_sum,
    input  logic signed [pireg_pkg::GAIN_W-1:0]  i_prop_gain,
    input  logic signed [pireg_pkg::GAIN_W-1:0]  i_integ_gain,
    input  logic signed [DATA_WIDTH-1:0]         i_out_min,
    input  logic [DATA_WIDTH-2:0]                i_out_max,
    output logic                                 o_valid,
    output logic signed [DATA_WIDTH-1:0]         o_drive
);

    localparam int unsigned P_W   = DATA_WIDTH + 1 + pireg_pkg::GAIN_W;
    localparam int unsigned I_W   = DATA_WIDTH + 2 + pireg_pkg::GAIN_W;
    localparam int unsigned ACC_W = I_W + 1;

    logic                     r_prod_valid;
    logic signed [P_W-1:0]    r_prod_p;
    logic signed [I_W-1:0]    r_prod_i;
    logic                     r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_drive;

    logic signed [P_W-1:0]   w_prod_p;
    logic signed [I_W-1:0]   w_prod_i;
    logic signed [P_W-1:0]   w_p_sh;
    logic signed [I_W-1:0]   w_i_sh;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] w_max;
    logic signed [ACC_W-1:0] w_min;
    logic signed [ACC_W-1:0] w_hi_lim;
    logic signed [ACC_W-1:0] w_lim;

    assign w_prod_p = P_W'(i_err) * P_W'(i_prop_gain);
    assign w_prod_i = I_W'(i_sum) * I_W'(i_integ_gain);

    always_comb begin
        w_p_sh = r_prod_p >>> GAIN_FRAC_BITS;
        w_i_sh = r_prod_i >>> GAIN_FRAC_BITS;
        w_acc  = ACC_W'(w_p_sh) + ACC_W'(w_i_sh);
        w_max  = $signed({{(ACC_W-DATA_WIDTH+1){1'b0}}, i_out_max});
        w_min  = ACC_W'(i_out_min);
        // Upper limit first, then the lower one, so out_min wins when the
        // limits are inverted.
        w_hi_lim = (w_acc > w_max) ? w_max : w_acc;
        w_lim    = (w_hi_lim < w_min) ? w_min : w_hi_lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_adv) begin
            r_prod_valid <= i_valid;
            r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod_p <= w_prod_p;
            r_prod_i <= w_prod_i;
            r_drive  <= w_lim[DATA_WIDTH-1:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

endmodule

// ----- rtl/core/pi_regulator_clamped.sv -----
// PI regulator with clamped drive and clamped integrator. A transfer with
// tuser 0 carries a measured sample in tdata; while the loop is enabled it
// yields one drive value, while disabled it yields nothing. A transfer with
// tuser 1 clears the integral and yields nothing. One transfer is accepted
// every cycle unless the output stalls; a drive value passes through
// the input register, the error and integrator register, the product register
// and the output register. The one-cycle rate is set by the
// integrator update, an add and a clamp that close on themselves each cycle.
// All stages stall together while a finished drive value waits on the
// master side. Write configuration only while no sample is in flight.
module pi_regulator_clamped #(
    parameter int unsigned DATA_WIDTH     = 16,
    parameter int unsigned GAIN_FRAC_BITS = 8,
    localparam int unsigned CFG_W         = (DATA_WIDTH > pireg_pkg::GAIN_W) ?
                                            DATA_WIDTH : pireg_pkg::GAIN_W,
    localparam int unsigned IN_TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int unsigned OUT_TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_wr_en,
    input  logic [pireg_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [CFG_W-1:0]                     i_cfg_wr_data,
    // Sample stream.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [IN_TDATA_W-1:0]                i_s_tdata,  // measurement
    input  logic                                 i_s_tuser,  // func
    // Drive stream.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [OUT_TDATA_W-1:0]               o_m_tdata   // drive
);

    logic signed [DATA_WIDTH-1:0]        w_setpoint;
    logic signed [pireg_pkg::GAIN_W-1:0] w_prop_gain;
    logic signed [pireg_pkg::GAIN_W-1:0] w_integ_gain;
    logic signed [DATA_WIDTH-1:0]        w_out_min;
    logic [DATA_WIDTH-2:0]               w_out_max;
    logic                                w_loop_enable;

    logic                         w_adv;
    logic                         r_in_valid;
    logic                         r_in_func;
    logic signed [DATA_WIDTH-1:0] r_in_meas;

    logic                         w_int_valid;
    logic signed [DATA_WIDTH:0]   w_int_err;
    logic signed [DATA_WIDTH+1:0] w_int_sum;
    logic                         w_out_valid;
    logic signed [DATA_WIDTH-1:0] w_drive;

    // The whole pipeline moves unless a drive value is held on the output.
    assign w_adv      = !w_out_valid || i_m_tready;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_func <= i_s_tuser;
            r_in_meas <= $signed(i_s_tdata[DATA_WIDTH-1:0]);
        end
    end

    pireg_cfg #(
        .DATA_WIDTH (DATA_WIDTH),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_setpoint    (w_setpoint),
        .o_prop_gain   (w_prop_gain),
        .o_integ_gain  (w_integ_gain),
        .o_out_min     (w_out_min),
        .o_out_max     (w_out_max),
        .o_loop_enable (w_loop_enable)
    );

    pireg_integ #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_integ (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_valid       (r_in_valid),
        .i_func        (r_in_func),
        .i_meas        (r_in_meas),
        .i_setpoint    (w_setpoint),
        .i_out_max     (w_out_max),
        .i_loop_enable (w_loop_enable),
        .o_valid       (w_int_valid),
        .o_err         (w_int_err),
        .o_sum         (w_int_sum)
    );

    pireg_drive #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (w_int_valid),
        .i_err        (w_int_err),
        .i_sum        (w_int_sum),
        .i_prop_gain  (w_prop_gain),
        .i_integ_gain (w_integ_gain),
        .i_out_min    (w_out_min),
        .i_out_max    (w_out_max),
        .o_valid      (w_out_valid),
        .o_drive      (w_drive)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'($unsigned(w_drive));

endmodule

// ----- verif/pi_regulator_clamped_test.sv -----
// Self-checking testbench for pi_regulator_clamped: a directed part and random phases
// of samples and integrator clears, checked against a cycle-free predictor.
// Depends on rtl/core/pireg_pkg.sv and rtl/core/pi_regulator_clamped.sv.
module pi_regulator_clamped_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pireg_pkg::*;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned CFG_W     = 16;
    // Four pipeline stages; drain them before touching configuration.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 85;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    class drive_scoreboard;
        longint setpoint, prop_gain, integ_gain, out_min, out_max, integral;
        bit loop_on;
        logic [DATA_W-1:0] drive_q[$];
        int unsigned errors, n_checked, n_samples, n_clears, n_ignored;
        int unsigned n_clip_high, n_clip_low, n_integ_sat;

        function new();
            setpoint   = 0;
            prop_gain  = longint'(PROP_GAIN_RESET);
            integ_gain = 0;
            out_min    = -(longint'(1) <<< (DATA_W - 1));
            out_max    = (longint'(1) <<< (DATA_W - 1)) - 1;
            loop_on    = 1'b0;
            integral   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SETPOINT:    setpoint   = longint'($signed(data));
                CFG_PROP_GAIN:   prop_gain  = longint'($signed(data));
                CFG_INTEG_GAIN:  integ_gain = longint'($signed(data));
                CFG_OUT_MIN:     out_min    = longint'($signed(data));
                CFG_OUT_MAX:     out_max    = longint'({1'b0, data[DATA_W-2:0]});
                CFG_LOOP_ENABLE: loop_on    = data[0];
                default: ;
            endcase
        endfunction

        // Works out the drive for one accepted transfer, if it yields one.
        function void note_input(t_func f, logic [DATA_W-1:0] meas);
            longint err, total, drv;
            if (f == FUNC_CLEAR) begin
                integral = 0;
                n_clears++;
                return;
            end
            n_samples++;
            if (!loop_on) begin
                n_ignored++;
                return;
            end
            err   = longint'($signed(meas)) - setpoint;
            total = integral + err;
            drv   = ((err * prop_gain) >>> FRAC_BITS) + ((total * integ_gain) >>> FRAC_BITS);
            // The upper limit is applied first, so an inverted pair ends at out_min.
            if (drv > out_max) begin
                drv = out_max;
                n_clip_high++;
            end
            if (drv < out_min) begin
                drv = out_min;
                n_clip_low++;
            end
            if (total > out_max || total < -out_max) n_integ_sat++;
            if (total > out_max) total = out_max;
            if (total < -out_max) total = -out_max;
            integral = total;
            drive_q.push_back(drv[DATA_W-1:0]);
        endfunction

        task flag_error(string what);
            $display("[%0t] drive check failed: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (drive_q.size() == 0) begin
                flag_error($sformatf("drive %0d arrived with none expected", $signed(got)));
                return;
            end
            want = drive_q.pop_front();
            n_checked++;
            if (got !== want)
                flag_error($sformatf("got %0d, expected %0d", $signed(got), $signed(want)));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_wr_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    i_s_tdata;   // measurement
    logic                 i_s_tuser;   // func
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [DATA_W-1:0]    o_m_tdata;   // drive

    drive_scoreboard sb;
    bit tx_burst;

    pi_regulator_clamped dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("pi_regulator_clamped: mismatch");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: short ready bursts with random stalls, now and then a long
    // stretch with no stall at all.
    initial begin
        int unsigned hold, stall;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                hold  = $urandom_range(50, 200);
                stall = 0;
            end else begin
                hold  = $urandom_range(1, 8);
                stall = pick_gap();
            end
            i_m_tready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    // Leaves the write enable high so back-to-back writes need no toggle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic close_writes();
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(t_func f, logic [DATA_W-1:0] meas);
        int unsigned gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= meas;
        i_s_tuser  <= f;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(f, meas);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.drive_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_measurement(longint bias);
        int unsigned r;
        longint off;
        r = $urandom_range(0, 99);
        if (r < 35) return DATA_W'($urandom);
        if (r < 85) begin
            off = longint'($urandom_range(0, 600)) - 300 + bias;
            return DATA_W'(sb.setpoint + off);
        end
        return ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000) ^ DATA_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain(int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if (r < 3) return CFG_W'($urandom);
        return CFG_W'(longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_config();
        logic [CFG_W-1:0] hi, lo, en;
        write_reg(CFG_SETPOINT, CFG_W'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            write_reg(CFG_PROP_GAIN, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            write_reg(CFG_INTEG_GAIN, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            write_reg(CFG_OUT_MAX, 16'h7FFF);
            write_reg(CFG_OUT_MIN, 16'h8000);
        end else begin
            write_reg(CFG_PROP_GAIN, pick_gain(1024));
            write_reg(CFG_INTEG_GAIN, pick_gain(256));
            // The top bit of the out_max data is dropped by the block.
            hi = ($urandom_range(0, 9) < 3) ? CFG_W'($urandom_range(0, 2000)) : CFG_W'($urandom);
            if ($urandom_range(0, 6) == 0)
                lo = CFG_W'($urandom_range(hi[DATA_W-2:0], 32767));
            else
                lo = CFG_W'(longint'($urandom_range(0, hi[DATA_W-2:0] + 32768)) - 32768);
            write_reg(CFG_OUT_MAX, hi);
            write_reg(CFG_OUT_MIN, lo);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom));
        en    = CFG_W'($urandom);
        en[0] = ($urandom_range(0, 99) < 85);
        write_reg(CFG_LOOP_ENABLE, en);
        close_writes();
    endtask

    initial begin
        longint bias;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wr_data <= '0;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= '0;
        i_s_tuser     <= FUNC_SAMPLE;
        tx_burst      = 1'b0;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Loop disabled after reset: samples are dropped.
        send_item(FUNC_SAMPLE, 16'h7FFF);
        send_item(FUNC_SAMPLE, 16'h8000);
        settle();

        // Reset gains with the loop running; spare indexes must be ignored.
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        write_reg(CFG_LOOP_ENABLE, 16'h0001);
        close_writes();
        send_item(FUNC_SAMPLE, 16'h7FFF);
        send_item(FUNC_SAMPLE, 16'h8000);
        send_item(FUNC_SAMPLE, 16'h0000);
        send_item(FUNC_SAMPLE, 16'hFFFF);
        send_item(FUNC_CLEAR, 16'h5A5A);
        settle();

        // Extreme gains and setpoint: the integral runs into its bound.
        write_reg(CFG_SETPOINT, 16'h8000);
        write_reg(CFG_PROP_GAIN, 16'h7FFF);
        write_reg(CFG_INTEG_GAIN, 16'h8000);
        write_reg(CFG_OUT_MIN, 16'h8000);
        write_reg(CFG_OUT_MAX, 16'hFFFF);
        close_writes();
        repeat (4) send_item(FUNC_SAMPLE, 16'h7FFF);
        send_item(FUNC_CLEAR, 16'hA5A5);
        repeat (2) send_item(FUNC_SAMPLE, 16'h8000);
        settle();

        // Inverted limits with a zero upper bound: out_min wins, integral pinned at 0.
        write_reg(CFG_OUT_MIN, 16'sd100);
        write_reg(CFG_OUT_MAX, 16'h8000);
        close_writes();
        send_item(FUNC_SAMPLE, 16'h0000);
        send_item(FUNC_SAMPLE, 16'h7FFF);
        send_item(FUNC_SAMPLE, 16'h8000);
        settle();

        // A clear while disabled still zeroes the integral.
        write_reg(CFG_OUT_MIN, 16'h8000);
        write_reg(CFG_OUT_MAX, 16'h7FFF);
        write_reg(CFG_INTEG_GAIN, 16'h0100);
        write_reg(CFG_LOOP_ENABLE, 16'h0001);
        close_writes();
        send_item(FUNC_SAMPLE, 16'h4000);
        settle();
        write_reg(CFG_LOOP_ENABLE, 16'hFFFE);
        close_writes();
        send_item(FUNC_SAMPLE, 16'h1234);
        send_item(FUNC_CLEAR, 16'h0000);
        settle();
        write_reg(CFG_LOOP_ENABLE, 16'h0001);
        close_writes();
        send_item(FUNC_SAMPLE, 16'h0100);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            tx_burst = ($urandom_range(0, 3) == 0);
            // A per-phase bias keeps the error one-signed long enough to saturate.
            bias = longint'($urandom_range(0, 400)) - 200;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 5)
                    send_item(FUNC_CLEAR, DATA_W'($urandom));
                else
                    send_item(FUNC_SAMPLE, pick_measurement(bias));
            end
            settle();
        end

        $display("Run covered %0d samples (%0d ignored) and %0d integrator clears.",
                 sb.n_samples, sb.n_ignored, sb.n_clears);
        $display("%0d drive values checked: %0d clipped high, %0d clipped low, %0d integral bounds.",
                 sb.n_checked, sb.n_clip_high, sb.n_clip_low, sb.n_integ_sat);
        if (sb.errors == 0) begin
            $display("pi_regulator_clamped: match");
        end else begin
            $display("pi_regulator_clamped: mismatch");
        end
        $finish;
    end

endmodule

// ----- pi_regulator_clamped.f -----
rtl/core/pireg_pkg.sv
rtl/core/pireg_cfg.sv
rtl/core/pireg_integ.sv
rtl/core/pireg_drive.sv
rtl/core/pi_regulator_clamped.sv
verif/pi_regulator_clamped_test.sv
